[src/itsf_pkg.sv]
`default_nettype none

package itsf_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = $clog2(WordW);
  localparam int unsigned ExpW   = 8;
  localparam int unsigned FracW  = 23;
  localparam int unsigned SigW   = FracW + 1;
  localparam int unsigned DropW  = WordW - SigW;
  localparam logic [ExpW-1:0] ExpBias = 8'd127;

  typedef enum logic {
    OP_UNSIGNED = 1'b0,
    OP_SIGNED   = 1'b1
  } opcode_e;

  // sign and magnitude of the integer
  typedef struct packed {
    logic             sign;
    logic             zero;
    logic [WordW-1:0] mag;
  } mag_stage_t;

  // magnitude with the position of its leading one
  typedef struct packed {
    logic             sign;
    logic             zero;
    logic [PosW-1:0]  pos;
    logic [WordW-1:0] mag;
  } pos_stage_t;

  // magnitude shifted so that the leading one sits in the top bit
  typedef struct packed {
    logic             sign;
    logic             zero;
    logic [PosW-1:0]  pos;
    logic [WordW-1:0] norm;
  } norm_stage_t;

endpackage

`default_nettype wire

[src/int_to_single_float_convert.sv]
`default_nettype none

// Integer to IEEE-754 single-precision converter.
//
// Input channel (in_valid_i / in_ready_o): one transaction carries a 32-bit
// word in int_word_i and opcode_i, which selects unsigned (OP_UNSIGNED) or
// two's complement (OP_SIGNED) reading. Output channel (out_valid_o /
// out_ready_i): one transaction per input, float_bits_o holds the single
// bits, rounded to nearest even. Zero gives +0.
//
// Four register stages: sign and magnitude, leading-one search, normalize
// shift, round and pack. Throughput is one transaction per cycle while the
// receiver holds out_ready_i high.
//
// Each stage carries its own valid bit and advances when it is empty or its
// successor takes its data, so a stalled receiver holds the last stage and
// lets bubbles ahead of it fill before in_ready_o drops. Nothing is dropped
// or repeated. Reset clears all valid bits; the data registers are not reset.
module int_to_single_float_convert
  import itsf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic             opcode_i,
  input  wire logic [WordW-1:0] int_word_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [WordW-1:0] float_bits_o
);

  // stage 1 -> 2
  logic        mag_valid;
  logic        mag_ready;
  mag_stage_t  mag_data;
  // stage 2 -> 3
  logic        pos_valid;
  logic        pos_ready;
  pos_stage_t  pos_data;
  // stage 3 -> 4
  logic        norm_valid;
  logic        norm_ready;
  norm_stage_t norm_data;

  // take the sign and form the magnitude
  itsf_magnitude u_magnitude (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .int_word_i  (int_word_i),
    .out_valid_o (mag_valid),
    .out_ready_i (mag_ready),
    .out_data_o  (mag_data)
  );

  // locate the leading one; its position sets the exponent
  itsf_lead_detect u_lead_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mag_valid),
    .in_ready_o  (mag_ready),
    .in_data_i   (mag_data),
    .out_valid_o (pos_valid),
    .out_ready_i (pos_ready),
    .out_data_o  (pos_data)
  );

  // align the leading one to the top bit
  itsf_normalize u_normalize (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pos_valid),
    .in_ready_o  (pos_ready),
    .in_data_i   (pos_data),
    .out_valid_o (norm_valid),
    .out_ready_i (norm_ready),
    .out_data_o  (norm_data)
  );

  // round the significand and pack sign, exponent and fraction
  itsf_round u_round (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (norm_valid),
    .in_ready_o   (norm_ready),
    .in_data_i    (norm_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .float_bits_o (float_bits_o)
  );

endmodule

`default_nettype wire

[src/itsf_magnitude.sv]
`default_nettype none

module itsf_magnitude
  import itsf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic             opcode_i,
  input  wire logic [WordW-1:0] int_word_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      mag_stage_t       out_data_o
);

  logic       valid_q;
  mag_stage_t data_q;
  mag_stage_t data_d;

  always_comb begin
    data_d.sign = (opcode_i == OP_SIGNED) && int_word_i[WordW-1];
    data_d.zero = (int_word_i == '0);
    data_d.mag  = data_d.sign ? ('0 - int_word_i) : int_word_i;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // an unsigned reading never yields a negative value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_UNSIGNED) |=> !data_q.sign)
    else $error("unsigned transaction produced a sign bit");

endmodule

`default_nettype wire

[src/itsf_lead_detect.sv]
`default_nettype none

module itsf_lead_detect
  import itsf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire mag_stage_t  in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      pos_stage_t  out_data_o
);

  logic       valid_q;
  pos_stage_t data_q;
  pos_stage_t data_d;

  // binary search for the leading one, halving the window each step
  always_comb begin
    logic [15:0] s16;
    logic [7:0]  s8;
    logic [3:0]  s4;
    logic [1:0]  s2;
    data_d.sign   = in_data_i.sign;
    data_d.zero   = in_data_i.zero;
    data_d.mag    = in_data_i.mag;
    data_d.pos[4] = |in_data_i.mag[31:16];
    s16           = data_d.pos[4] ? in_data_i.mag[31:16] : in_data_i.mag[15:0];
    data_d.pos[3] = |s16[15:8];
    s8            = data_d.pos[3] ? s16[15:8] : s16[7:0];
    data_d.pos[2] = |s8[7:4];
    s4            = data_d.pos[2] ? s8[7:4] : s8[3:0];
    data_d.pos[1] = |s4[3:2];
    s2            = data_d.pos[1] ? s4[3:2] : s4[1:0];
    data_d.pos[0] = s2[1];
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // the found position holds a one and nothing above it is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !data_q.zero) |->
      (data_q.mag[data_q.pos] && ((data_q.mag >> data_q.pos) == 32'd1)))
    else $error("leading one position is wrong");

endmodule

`default_nettype wire

[src/itsf_normalize.sv]
`default_nettype none

module itsf_normalize
  import itsf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire pos_stage_t  in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      norm_stage_t out_data_o
);

  logic        valid_q;
  norm_stage_t data_q;
  norm_stage_t data_d;

  // shift by (WordW-1 - pos), which is the bitwise inverse of pos
  always_comb begin
    data_d.sign = in_data_i.sign;
    data_d.zero = in_data_i.zero;
    data_d.pos  = in_data_i.pos;
    data_d.norm = in_data_i.mag << (~in_data_i.pos);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[src/itsf_round.sv]
`default_nettype none

module itsf_round
  import itsf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire norm_stage_t      in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [WordW-1:0] float_bits_o
);

  logic             valid_q;
  logic [WordW-1:0] float_q;
  logic [WordW-1:0] float_d;

  // round to nearest even on the dropped bits; a carry bumps the exponent
  always_comb begin
    logic            guard;
    logic            sticky;
    logic            round_up;
    logic [SigW:0]   sum;
    logic [ExpW-1:0] expo;
    guard    = in_data_i.norm[DropW-1];
    sticky   = |in_data_i.norm[DropW-2:0];
    round_up = guard && (sticky || in_data_i.norm[DropW]);
    sum      = {1'b0, in_data_i.norm[WordW-1:DropW]} + {{SigW{1'b0}}, round_up};
    expo     = {{(ExpW-PosW){1'b0}}, in_data_i.pos} + ExpBias
               + {{(ExpW-1){1'b0}}, sum[SigW]};
    float_d  = in_data_i.zero ? '0 : {in_data_i.sign, expo, sum[FracW-1:0]};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      float_q <= float_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign float_bits_o = float_q;

  // a 32-bit integer never reaches an exponent above 2^32
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (float_q[30:23] <= 8'd159))
    else $error("exponent out of integer range");

  // no subnormal or signed-zero results: zero exponent means all bits zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && float_q[30:23] == '0) |-> (float_q == '0))
    else $error("zero exponent with nonzero bits");

endmodule

`default_nettype wire

[bench/itsf_tb_pkg.sv]
package itsf_tb_pkg;

  import itsf_pkg::*;

  typedef struct {
    opcode_e          op;
    logic [WordW-1:0] word;
    logic [WordW-1:0] bits;
  } single_expect_t;

  class float_scoreboard;

    single_expect_t expected_q[$];
    int unsigned    mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Round to nearest, ties to even, when the magnitude is wider than the significand.
    function logic [WordW-1:0] single_bits(opcode_e op, logic [WordW-1:0] word);
      logic             neg;
      logic [WordW-1:0] mag;
      logic [WordW-1:0] rem;
      logic [WordW-1:0] half;
      logic [WordW:0]   kept;
      logic [ExpW-1:0]  expo;
      int unsigned      lead;
      int unsigned      sh;
      neg = (op == OP_SIGNED) && word[WordW-1];
      mag = neg ? -word : word;
      if (mag == '0) return '0;
      lead = WordW - 1;
      while (lead > 0 && !mag[lead]) lead--;
      expo = ExpBias + ExpW'(lead);
      if (lead <= FracW) return {neg, expo, FracW'(mag << (FracW - lead))};
      sh   = lead - FracW;
      kept = (WordW + 1)'(mag >> sh);
      rem  = mag & ((WordW'(1) << sh) - WordW'(1));
      half = WordW'(1) << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept++;
      // carry out of the significand: renormalize
      if (kept[SigW]) begin
        kept = kept >> 1;
        expo++;
      end
      return {neg, expo, kept[FracW-1:0]};
    endfunction

    function void note_input(opcode_e op, logic [WordW-1:0] word);
      single_expect_t e;
      e.op   = op;
      e.word = word;
      e.bits = single_bits(op, word);
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [WordW-1:0] got);
      single_expect_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %h arrived with no transaction outstanding", got);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e.bits) begin
        mismatches++;
        if (mismatches <= 10)
          $display("float_bits mismatch: %s word %h expected %h got %h",
                   e.op.name(), e.word, e.bits, got);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

  endclass

endpackage

[bench/tb_int_to_single_float_convert.sv]
module tb_int_to_single_float_convert;

  timeunit 1ns;
  timeprecision 1ps;

  import itsf_pkg::*;
  import itsf_tb_pkg::*;

  // Cycles with no transaction on either side before the run is declared hung.
  localparam int unsigned HangLimit   = 2000;
  // Cycles to wait after the last result: four stages plus margin.
  localparam int unsigned SettleTicks = 16;
  localparam int unsigned HoldTicks   = 60;
  localparam int unsigned PhaseItems  = 420;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_q  = 1'b0;
  logic             in_ready_o;
  opcode_e          opcode_q    = OP_UNSIGNED;
  logic [WordW-1:0] int_word_q  = '0;
  logic             out_valid_o;
  logic             out_ready_q = 1'b0;
  logic [WordW-1:0] float_bits_o;

  float_scoreboard  sb = new();

  // Idle rates in percent, set per phase by the stimulus process.
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  // Bump to ask the receiver for one long hold-off.
  int unsigned      hold_token     = 0;
  int unsigned      quiet_ticks    = 0;

  always #2 clk_i = ~clk_i;

  int_to_single_float_convert u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_q),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_q),
    .int_word_i   (int_word_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_q),
    .float_bits_o (float_bits_o)
  );

  // Monitor both channels on the pre-edge values. Note the input first so a
  // transaction can never be checked ahead of its own expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_q && in_ready_o) sb.note_input(opcode_q, int_word_q);
      if (out_valid_o && out_ready_q) sb.check_result(float_bits_o);
      if ((in_valid_q && in_ready_o) || (out_valid_o && out_ready_q)) begin
        quiet_ticks <= 0;
      end else if (quiet_ticks + 1 >= HangLimit) begin
        $display("timeout: no transaction for %0d cycles", HangLimit);
        $display("[int_to_single_float_convert] ERROR");
        $finish;
      end else begin
        quiet_ticks <= quiet_ticks + 1;
      end
    end
  end

  // Receiver: stall at random, or hold off for a counted stretch on request.
  initial begin : receiver
    int unsigned hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_ready_q <= 1'b0;
        repeat (HoldTicks) @(posedge clk_i);
      end else begin
        out_ready_q <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one transaction after an optional random gap; return at the edge
  // that accepts it.
  task automatic send_word(input opcode_e op, input logic [WordW-1:0] word);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_q <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    opcode_q   <= op;
    int_word_q <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain();
    in_valid_q <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Shape words so that every leading-one position, every rounding shift,
  // ties and significand carries all show up often.
  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] w;
    int unsigned      lead;
    int unsigned      sh;
    w = $urandom();
    case ($urandom_range(4))
      0: ;
      1: begin
        lead    = $urandom_range(WordW - 1);
        w       = w >> (WordW - 1 - lead);
        w[lead] = 1'b1;
      end
      2: begin
        // exact halfway between two representable values
        lead    = $urandom_range(WordW - 1, SigW);
        sh      = lead - FracW;
        w       = w >> (WordW - 1 - lead);
        w[lead] = 1'b1;
        w       = (w >> sh << sh) | (WordW'(1) << (sh - 1));
      end
      3: begin
        // runs of ones that round up into the next binade
        w = {WordW{1'b1}} >> $urandom_range(WordW - 1);
        w = w ^ WordW'($urandom_range(255));
      end
      default: w = -WordW'($urandom_range(1000));
    endcase
    return w;
  endfunction

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros, extremes, the most negative word, ties and carries.
    send_word(OP_UNSIGNED, 32'h0000_0000);
    send_word(OP_SIGNED,   32'h0000_0000);
    send_word(OP_UNSIGNED, 32'hFFFF_FFFF);
    send_word(OP_SIGNED,   32'hFFFF_FFFF);
    send_word(OP_SIGNED,   32'h8000_0000);
    send_word(OP_UNSIGNED, 32'h8000_0000);
    send_word(OP_SIGNED,   32'h7FFF_FFFF);
    send_word(OP_UNSIGNED, 32'h0000_0001);
    send_word(OP_SIGNED,   32'h0000_0001);
    send_word(OP_UNSIGNED, 32'h00FF_FFFF);
    send_word(OP_UNSIGNED, 32'h0080_0000);
    send_word(OP_UNSIGNED, 32'h0100_0001);
    send_word(OP_UNSIGNED, 32'h0100_0003);
    send_word(OP_UNSIGNED, 32'h01FF_FFFF);
    send_word(OP_SIGNED,   32'h8000_0001);
    send_word(OP_SIGNED,   32'hFF00_0001);
    send_word(OP_UNSIGNED, 32'h1234_5678);
    send_word(OP_SIGNED,   32'hEDCB_A988);
    send_word(OP_UNSIGNED, 32'hFFFF_FF80);
    send_word(OP_UNSIGNED, 32'hFFFF_FF7F);
    send_word(OP_UNSIGNED, 32'h8000_0080);
    send_word(OP_UNSIGNED, 32'h8000_0180);
    send_word(OP_SIGNED,   32'hAAAA_AAAA);
    send_word(OP_UNSIGNED, 32'h5555_5555);
    drain();

    // Random phases: none idle, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // Hold the receiver off while the sender keeps pushing; the pipe
        // fills and in_ready_o has to drop.
        if (phase == 0 && n == PhaseItems / 2) hold_token++;
        send_word(opcode_e'($urandom_range(1)), pick_word());
      end
      drain();
    end

    repeat (SettleTicks) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      sb.mismatches += sb.outstanding();
      $display("%0d transactions never produced a result", sb.outstanding());
    end
    if (sb.mismatches == 0) begin
      $display("[int_to_single_float_convert] OK");
    end else begin
      $display("[int_to_single_float_convert] ERROR");
    end
    $finish;
  end

endmodule
